### hw/rtl/ptcv_pkg.sv
// Package with the shared types, tables and helper functions of the point-to-cube expander.
package ptcv_pkg;

  // Vertices per point, and the counter width that walks them.
  localparam int NUM_VTX   = 24;
  localparam int VTX_W     = 5;
  localparam int NUM_FACES = 6;
  localparam int FACE_W    = 3;

  // Datapath widths: corner coordinate, one product, one row sum.
  localparam int COORD_W = 17;
  localparam int PROD_W  = 33;
  localparam int SUM_W   = 35;
  localparam int RND_W   = 36;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int HALF_W     = 15;
  localparam int AMB_W      = 9;

  // Register reset values: identity matrix, half size 102, ambient one half.
  localparam logic [63:0] MAT_ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [63:0] MAT_ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [63:0] MAT_ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [63:0] MAT_ROW3_RST = 64'h1000_0000_0000_0000;
  localparam logic [HALF_W-1:0] BOX_HALF_RST = 15'd102;
  localparam logic [AMB_W-1:0]  AMBIENT_RST  = 9'd128;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAT_ROW0 = 3'd0,
    CFG_MAT_ROW1 = 3'd1,
    CFG_MAT_ROW2 = 3'd2,
    CFG_MAT_ROW3 = 3'd3,
    CFG_BOX_HALF = 3'd4,
    CFG_AMBIENT  = 3'd5
  } cfg_idx_t;

  // Input transaction payload.
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
    logic               tex_u;
    logic               tex_v;
    logic [8:0]         color_r;
    logic [8:0]         color_g;
    logic [8:0]         color_b;
    logic               end_strip;
    logic               last_vertex;
  } out_t;

  // Per-vertex attributes that ride along with the transform pipeline.
  typedef struct packed {
    logic       tex_u;
    logic       tex_v;
    logic [8:0] color_r;
    logic [8:0] color_g;
    logic       end_strip;
    logic       last_vertex;
  } side_t;

  // Corner signs per vertex as {x, y, z}; a set bit adds the half size.
  localparam logic [2:0] CORNER_SIGN [NUM_VTX] = '{
    3'b111, 3'b101, 3'b110, 3'b100,
    3'b111, 3'b011, 3'b101, 3'b001,
    3'b111, 3'b110, 3'b011, 3'b010,
    3'b000, 3'b010, 3'b100, 3'b110,
    3'b000, 3'b001, 3'b010, 3'b011,
    3'b000, 3'b100, 3'b001, 3'b101
  };

  // Unclamped face brightness in Q0.8 for the fixed light direction.
  localparam logic signed [9:0] FACE_LIGHT [NUM_FACES] = '{
    -10'sd109, -10'sd188, 10'sd217, 10'sd188, 10'sd109, -10'sd217
  };

  // Floor of n / 5 by reciprocal multiply; exact for every n below 2048.
  function automatic logic [8:0] div5(input logic [10:0] n);
    logic [26:0] p;
    p = 27'(n) * 27'd52429;
    return p[26:18];
  endfunction

  // Clamp a rounded, shifted sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] t);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = RND_W'(32'sh7FFF_FFFF);
    lo = RND_W'(32'sh8000_0000);
    if (t > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (t < lo) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

endpackage

### hw/rtl/point_to_cube_vertex_expander.sv
// Top level of the point-to-cube expander: config registers, vertex sequencer, corner stage.
// Throughput: one vertex per cycle while a point is in flight; the next point is taken
// at the edge that issues the current point's last vertex, set by the 24-step sequencer.
// Pipeline: sequencer, corner/color stage, product stage, row-sum stage, round/saturate stage.
// Reset (synchronous, active low) clears the sequencer and valid bits and loads the identity
// matrix, half size 102 and ambient 128.
module point_to_cube_vertex_expander (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ptcv_pkg::in_t                       in_data,
  output logic                                out_valid,
  output ptcv_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptcv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptcv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [3:0][63:0]                    mat_r;
  logic [ptcv_pkg::HALF_W-1:0]         half_r;
  logic [ptcv_pkg::AMB_W-1:0]          amb_r;

  // Sequencer state.
  ptcv_pkg::in_t                       pos_r;
  logic                                act_r;
  logic                                act_nxt;
  logic [ptcv_pkg::VTX_W-1:0]          vtx_r;
  logic [ptcv_pkg::VTX_W-1:0]          vtx_nxt;
  logic                                in_accept;
  logic                                last_issue;

  // Corner stage.
  logic [ptcv_pkg::FACE_W-1:0]         face;
  logic [2:0]                          sgn;
  logic signed [ptcv_pkg::COORD_W-1:0] half_s;
  logic signed [ptcv_pkg::COORD_W-1:0] cx_nxt, cy_nxt, cz_nxt;
  logic signed [ptcv_pkg::COORD_W-1:0] cx_r, cy_r, cz_r;
  logic signed [10:0]                  light;
  logic signed [10:0]                  amb_s;
  logic signed [10:0]                  lo_clamp;
  logic signed [10:0]                  bright;
  logic [8:0]                          bq;
  ptcv_pkg::side_t                     side_nxt;
  ptcv_pkg::side_t                     side_r;
  logic                                crn_vld_r;

  // Configuration writes; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= ptcv_pkg::MAT_ROW0_RST;
      mat_r[1] <= ptcv_pkg::MAT_ROW1_RST;
      mat_r[2] <= ptcv_pkg::MAT_ROW2_RST;
      mat_r[3] <= ptcv_pkg::MAT_ROW3_RST;
      half_r   <= ptcv_pkg::BOX_HALF_RST;
      amb_r    <= ptcv_pkg::AMBIENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptcv_pkg::CFG_MAT_ROW0: mat_r[0] <= cfg_data;
        ptcv_pkg::CFG_MAT_ROW1: mat_r[1] <= cfg_data;
        ptcv_pkg::CFG_MAT_ROW2: mat_r[2] <= cfg_data;
        ptcv_pkg::CFG_MAT_ROW3: mat_r[3] <= cfg_data;
        ptcv_pkg::CFG_BOX_HALF: half_r   <= cfg_data[ptcv_pkg::HALF_W-1:0];
        ptcv_pkg::CFG_AMBIENT:  amb_r    <= cfg_data[ptcv_pkg::AMB_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex sequencer: a new point may enter on the cycle the last vertex issues.
  assign last_issue = act_r && (vtx_r == ptcv_pkg::VTX_W'(ptcv_pkg::NUM_VTX - 1));
  assign busy       = act_r && !last_issue;
  assign in_accept  = start && !busy;

  always_comb begin
    act_nxt = act_r;
    vtx_nxt = vtx_r;
    if (in_accept) begin
      act_nxt = 1'b1;
      vtx_nxt = '0;
    end else if (last_issue) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      vtx_nxt = vtx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      vtx_r <= '0;
    end else begin
      act_r <= act_nxt;
      vtx_r <= vtx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pos_r <= in_data;
    end
  end

  // Corner coordinates from the sign table.
  assign face   = vtx_r[ptcv_pkg::VTX_W-1:2];
  assign sgn    = ptcv_pkg::CORNER_SIGN[vtx_r];
  assign half_s = $signed({2'b00, half_r});

  always_comb begin
    cx_nxt = sgn[2] ? 17'(pos_r.pos_x) + half_s : 17'(pos_r.pos_x) - half_s;
    cy_nxt = sgn[1] ? 17'(pos_r.pos_y) + half_s : 17'(pos_r.pos_y) - half_s;
    cz_nxt = sgn[0] ? 17'(pos_r.pos_z) + half_s : 17'(pos_r.pos_z) - half_s;
  end

  // Face brightness clamped to ambient..1.0, then scaled by 0.8 and 1.2 with rounding.
  always_comb begin
    light    = 11'(ptcv_pkg::FACE_LIGHT[face]);
    amb_s    = $signed({2'b00, amb_r});
    lo_clamp = (light < amb_s) ? amb_s : light;
    bright   = (lo_clamp > 11'sd256) ? 11'sd256 : lo_clamp;
    bq       = bright[8:0];
    side_nxt.tex_u       = vtx_r[0];
    side_nxt.tex_v       = !vtx_r[1];
    side_nxt.color_r     = ptcv_pkg::div5({bq, 2'b00} + 11'd2);
    side_nxt.color_g     = ptcv_pkg::div5({bq, 2'b00} + {1'b0, bq, 1'b0} + 11'd2);
    side_nxt.end_strip   = (vtx_r[1:0] == 2'd3);
    side_nxt.last_vertex = last_issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crn_vld_r <= 1'b0;
    end else begin
      crn_vld_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    side_r <= side_nxt;
  end

  // Matrix transform and output register.
  ptcv_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (crn_vld_r),
    .in_cx     (cx_r),
    .in_cy     (cy_r),
    .in_cz     (cz_r),
    .in_side   (side_r),
    .mat       (mat_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The sequencer steps by one vertex while a point is in flight.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !last_issue) |=> (act_r && vtx_r == $past(vtx_r) + 5'd1))
    else $error("vertex sequencer skipped or repeated a vertex");

  // An accepted point starts at its first vertex.
  a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (act_r && vtx_r == '0))
    else $error("accepted point did not start at vertex zero");

  // The last vertex of a point always closes a strip.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_vertex) |-> out_data.end_strip)
    else $error("last vertex does not end a strip");

  // Red is scaled by 0.8 and green by 1.2 from the same brightness.
  a_color_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.color_r <= out_data.color_g &&
                   out_data.color_g == out_data.color_b))
    else $error("face color channels are inconsistent");

endmodule

### hw/rtl/ptcv_xform.sv
// Three-stage matrix transform of one corner per cycle, with rounding and saturation.
module ptcv_xform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic signed [ptcv_pkg::COORD_W-1:0]   in_cx,
  input  logic signed [ptcv_pkg::COORD_W-1:0]   in_cy,
  input  logic signed [ptcv_pkg::COORD_W-1:0]   in_cz,
  input  ptcv_pkg::side_t                       in_side,
  input  logic [3:0][63:0]                      mat,
  output logic                                  out_valid,
  output ptcv_pkg::out_t                        out_data
);

  localparam int RND_W  = ptcv_pkg::RND_W;
  localparam int SUM_W  = ptcv_pkg::SUM_W;
  localparam int PROD_W = ptcv_pkg::PROD_W;

  // Stage registers.
  logic signed [ptcv_pkg::PROD_W-1:0] prod_r [4][4];
  logic signed [ptcv_pkg::PROD_W-1:0] prod_nxt [4][4];
  logic signed [ptcv_pkg::SUM_W-1:0]  sum_r [4];
  logic signed [ptcv_pkg::SUM_W-1:0]  sum_nxt [4];
  logic signed [31:0]                 clip_nxt [4];
  logic                               prod_vld_r;
  logic                               sum_vld_r;
  logic                               out_vld_r;
  ptcv_pkg::side_t                    prod_side_r;
  ptcv_pkg::side_t                    sum_side_r;
  ptcv_pkg::out_t                     out_r;
  logic signed [ptcv_pkg::COORD_W-1:0] vec [3];

  assign vec[0] = in_cx;
  assign vec[1] = in_cy;
  assign vec[2] = in_cz;

  // Products of every matrix entry with the corner; w is 1.0, a shift by eight.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = PROD_W'($signed(mat[r][16*c +: 16]) * vec[c]);
      end
      prod_nxt[r][3] = PROD_W'($signed({mat[r][63:48], 8'b0}));
    end
  end

  // Row sums of the four products.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
                 + SUM_W'(prod_r[r][2]) + SUM_W'(prod_r[r][3]);
    end
  end

  // Round half up from Q.20 to Q.8, then saturate.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip_nxt[r] = ptcv_pkg::sat32((RND_W'(sum_r[r]) + RND_W'(2048)) >>> 12);
    end
  end

  // Valid bits travel with the data; the receiver never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      prod_vld_r <= in_valid;
      sum_vld_r  <= prod_vld_r;
      out_vld_r  <= sum_vld_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    prod_side_r <= in_side;
    sum_r       <= sum_nxt;
    sum_side_r  <= prod_side_r;
    out_r.clip_x      <= clip_nxt[0];
    out_r.clip_y      <= clip_nxt[1];
    out_r.clip_z      <= clip_nxt[2];
    out_r.clip_w      <= clip_nxt[3];
    out_r.tex_u       <= sum_side_r.tex_u;
    out_r.tex_v       <= sum_side_r.tex_v;
    out_r.color_r     <= sum_side_r.color_r;
    out_r.color_g     <= sum_side_r.color_g;
    out_r.color_b     <= sum_side_r.color_g;
    out_r.end_strip   <= sum_side_r.end_strip;
    out_r.last_vertex <= sum_side_r.last_vertex;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the point-to-cube vertex expander with directed and random points.
module tb_top;

  localparam int VERTS_PER_POINT = 24;
  localparam int CORNERS         = 4;
  localparam int MAT_ROWS        = 4;
  localparam int ONE_Q8          = 256;
  localparam int ROUND_HALF      = 2048;
  localparam int FRAC_SHIFT      = 12;
  localparam int MAX_GAP         = 30;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_POINTS   = 115;
  localparam int NUM_PHASES      = 4;
  localparam longint CLIP_MAX    = 2147483647;
  localparam longint CLIP_MIN    = -CLIP_MAX - 1;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [ptcv_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [ptcv_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam ptcv_pkg::cfg_idx_t MAT_ROW_IDX [MAT_ROWS] = '{
    ptcv_pkg::CFG_MAT_ROW0, ptcv_pkg::CFG_MAT_ROW1,
    ptcv_pkg::CFG_MAT_ROW2, ptcv_pkg::CFG_MAT_ROW3
  };

  // Sender idle percentage for each random phase.
  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 69, 0, 10};

  // Corner signs per vertex as {x, y, z}; a set bit adds the half size.
  localparam logic [2:0] CUBE_CORNERS [VERTS_PER_POINT] = '{
    3'b111, 3'b101, 3'b110, 3'b100,
    3'b111, 3'b011, 3'b101, 3'b001,
    3'b111, 3'b110, 3'b011, 3'b010,
    3'b000, 3'b010, 3'b100, 3'b110,
    3'b000, 3'b001, 3'b010, 3'b011,
    3'b000, 3'b100, 3'b001, 3'b101
  };

  // Unclamped brightness of each face under the fixed light, Q0.8.
  localparam int FACE_BRIGHTNESS [ptcv_pkg::NUM_FACES] = '{-109, -188, 217, 188, 109, -217};

  typedef enum logic {STEP_WRITE, STEP_POINT} step_kind_t;

  typedef struct {
    step_kind_t                      kind;
    logic [ptcv_pkg::CFG_IDX_W-1:0]  idx;
    logic [ptcv_pkg::CFG_DATA_W-1:0] data;
    ptcv_pkg::in_t                   pt;
    logic                            typed;
    ptcv_pkg::out_t                  want;
  } step_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            start     = 1'b0;
  logic                            busy;
  ptcv_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  ptcv_pkg::out_t                  out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ptcv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ptcv_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // First vertex typed in by hand, travelling with the point it belongs to.
  logic           first_typed = 1'b0;
  ptcv_pkg::out_t first_want  = '0;

  // Predictor copy of the registers.
  logic [ptcv_pkg::CFG_DATA_W-1:0] mat_row_q [MAT_ROWS];
  logic [ptcv_pkg::HALF_W-1:0]     half_size_q;
  logic [ptcv_pkg::AMB_W-1:0]      ambient_q;

  ptcv_pkg::out_t pending_vertices [$];
  step_t          directed_steps [$];
  int unsigned    points_sent   = 0;
  int unsigned    vertices_seen = 0;
  int unsigned    mismatches    = 0;
  int             sender_idle_pct = 0;

  point_to_cube_vertex_expander dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t: vertex %0d: %s", $time, vertices_seen, msg);
  endtask

  task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  task automatic compare_vertex(ptcv_pkg::out_t got, ptcv_pkg::out_t want);
    check_field("clip_x", got.clip_x, want.clip_x);
    check_field("clip_y", got.clip_y, want.clip_y);
    check_field("clip_z", got.clip_z, want.clip_z);
    check_field("clip_w", got.clip_w, want.clip_w);
    check_field("tex_u", got.tex_u, want.tex_u);
    check_field("tex_v", got.tex_v, want.tex_v);
    check_field("color_r", got.color_r, want.color_r);
    check_field("color_g", got.color_g, want.color_g);
    check_field("color_b", got.color_b, want.color_b);
    check_field("end_strip", got.end_strip, want.end_strip);
    check_field("last_vertex", got.last_vertex, want.last_vertex);
  endtask

  // Works out the 24 cube vertices of one point and queues them in output order.
  function automatic void expand_point(ptcv_pkg::in_t pt);
    longint             corner [MAT_ROWS];
    longint             clip [MAT_ROWS];
    longint             half;
    longint             acc;
    logic signed [15:0] coef;
    int                 bright;
    ptcv_pkg::out_t     vtx;
    half = longint'(half_size_q);
    for (int k = 0; k < VERTS_PER_POINT; k++) begin
      corner[0] = longint'(pt.pos_x) + (CUBE_CORNERS[k][2] ? half : -half);
      corner[1] = longint'(pt.pos_y) + (CUBE_CORNERS[k][1] ? half : -half);
      corner[2] = longint'(pt.pos_z) + (CUBE_CORNERS[k][0] ? half : -half);
      corner[3] = ONE_Q8;
      // Row sums are exact; round half up, then clamp to 32 bits.
      for (int r = 0; r < MAT_ROWS; r++) begin
        acc = 0;
        for (int c = 0; c < MAT_ROWS; c++) begin
          coef = mat_row_q[r][16*c +: 16];
          acc += longint'(coef) * corner[c];
        end
        acc = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        if (acc > CLIP_MAX) acc = CLIP_MAX;
        if (acc < CLIP_MIN) acc = CLIP_MIN;
        clip[r] = acc;
      end
      // Face brightness clamped between ambient and one.
      bright = FACE_BRIGHTNESS[k / CORNERS];
      if (bright < int'(ambient_q)) bright = int'(ambient_q);
      if (bright > ONE_Q8) bright = ONE_Q8;
      vtx.clip_x      = clip[0][31:0];
      vtx.clip_y      = clip[1][31:0];
      vtx.clip_z      = clip[2][31:0];
      vtx.clip_w      = clip[3][31:0];
      vtx.tex_u       = (k % 2) == 1;
      vtx.tex_v       = (k % CORNERS) < 2;
      vtx.color_r     = 9'((bright * 4 + 2) / 5);
      vtx.color_g     = 9'((bright * 6 + 2) / 5);
      vtx.color_b     = vtx.color_g;
      vtx.end_strip   = (k % CORNERS) == CORNERS - 1;
      vtx.last_vertex = k == VERTS_PER_POINT - 1;
      pending_vertices = {pending_vertices, vtx};
    end
  endfunction

  // Watch all three channels: check results, follow register writes, predict accepted points.
  always @(posedge clk) begin
    if (!rst_n) begin
      mat_row_q[0] = 64'h0000_0000_0000_1000;
      mat_row_q[1] = 64'h0000_0000_1000_0000;
      mat_row_q[2] = 64'h0000_1000_0000_0000;
      mat_row_q[3] = 64'h1000_0000_0000_0000;
      half_size_q  = 15'd102;
      ambient_q    = 9'd128;
    end else begin
      if (out_valid) begin
        if (pending_vertices.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          compare_vertex(out_data, pending_vertices.pop_front());
        end
        vertices_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ptcv_pkg::CFG_MAT_ROW0, ptcv_pkg::CFG_MAT_ROW1, ptcv_pkg::CFG_MAT_ROW2,
          ptcv_pkg::CFG_MAT_ROW3: begin
            mat_row_q[cfg_index[1:0]] = cfg_data;
          end
          ptcv_pkg::CFG_BOX_HALF: half_size_q = cfg_data[ptcv_pkg::HALF_W-1:0];
          ptcv_pkg::CFG_AMBIENT:  ambient_q = cfg_data[ptcv_pkg::AMB_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expand_point(in_data);
        if (first_typed) begin
          pending_vertices[pending_vertices.size() - VERTS_PER_POINT] = first_want;
        end
      end
    end
  end

  // Lowers start and waits until every queued vertex has come out.
  task automatic wait_drained();
    start <= 1'b0;
    while (vertices_seen < VERTS_PER_POINT * points_sent) @(posedge clk);
  endtask

  // One register write transaction; valid stays up until the next driver call.
  task automatic write_reg(logic [ptcv_pkg::CFG_IDX_W-1:0] idx,
                           logic [ptcv_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // One point transaction; start stays high so back-to-back points run at full rate.
  task automatic send_point(ptcv_pkg::in_t pt, logic typed, ptcv_pkg::out_t want);
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    start       <= 1'b1;
    in_data     <= pt;
    first_typed <= typed;
    first_want  <= want;
    do @(posedge clk); while (!(start && !busy));
    points_sent++;
  endtask

  function automatic void add_write(logic [ptcv_pkg::CFG_IDX_W-1:0] idx,
                                    logic [ptcv_pkg::CFG_DATA_W-1:0] val);
    step_t s;
    s.kind  = STEP_WRITE;
    s.idx   = idx;
    s.data  = val;
    s.pt    = '0;
    s.typed = 1'b0;
    s.want  = '0;
    directed_steps = {directed_steps, s};
  endfunction

  function automatic void add_point(int x, int y, int z);
    step_t s;
    s.kind     = STEP_POINT;
    s.idx      = '0;
    s.data     = '0;
    s.pt.pos_x = 16'(x);
    s.pt.pos_y = 16'(y);
    s.pt.pos_z = 16'(z);
    s.typed    = 1'b0;
    s.want     = '0;
    directed_steps = {directed_steps, s};
  endfunction

  // Point whose first vertex (face 0, corner 0, identity w row) is typed in.
  function automatic void add_checked_point(int x, int y, int z, int cx, int cy, int cz,
                                            int red, int green);
    ptcv_pkg::out_t w;
    add_point(x, y, z);
    w         = '0;
    w.clip_x  = cx;
    w.clip_y  = cy;
    w.clip_z  = cz;
    w.clip_w  = ONE_Q8;
    w.tex_v   = 1'b1;
    w.color_r = 9'(red);
    w.color_g = 9'(green);
    w.color_b = 9'(green);
    directed_steps[directed_steps.size() - 1].typed = 1'b1;
    directed_steps[directed_steps.size() - 1].want  = w;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random register setup for one phase, with a write to an unused index mixed in.
  task automatic randomize_setup();
    for (int r = 0; r < MAT_ROWS; r++) begin
      write_reg(MAT_ROW_IDX[r], {$urandom, $urandom});
    end
    write_reg(ptcv_pkg::CFG_BOX_HALF, {$urandom, $urandom});
    write_reg(ptcv_pkg::CFG_AMBIENT, {$urandom, $urandom});
    write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
  endtask

  initial begin
    ptcv_pkg::in_t pt;

    // Reset values: identity matrix, half size 102, ambient one half.
    add_checked_point(0, 0, 0, 102, 102, 102, 102, 154);
    add_checked_point(32767, -32768, 0, 32869, -32666, 102, 102, 154);
    add_checked_point(-32768, 32767, -1, -32666, 32869, 101, 102, 154);
    add_point(16'h1234, -16'h0ABC, 16'h7F00);
    // Ambient at zero, written with junk in the upper bits.
    add_write(ptcv_pkg::CFG_AMBIENT, 64'hFFFF_FFFF_FFFF_FE00);
    add_checked_point(0, 0, 0, 102, 102, 102, 0, 0);
    // Ambient at one, then above one where the upper clamp wins.
    add_write(ptcv_pkg::CFG_AMBIENT, 64'h0000_0000_0000_0100);
    add_checked_point(0, 0, 0, 102, 102, 102, 205, 307);
    add_write(ptcv_pkg::CFG_AMBIENT, 64'h0000_0000_0000_01FF);
    add_checked_point(-5, 7, 300, 97, 109, 402, 205, 307);
    add_write(ptcv_pkg::CFG_AMBIENT, 64'hABCD_0000_0000_00C8);
    add_point(16'h1234, -16'h0ABC, 16'h7F00);
    // Half size at both extremes.
    add_write(ptcv_pkg::CFG_BOX_HALF, 64'hFFFF_FFFF_FFFF_8000);
    add_checked_point(100, -100, 5, 100, -100, 5, 160, 240);
    add_write(ptcv_pkg::CFG_BOX_HALF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_checked_point(32767, 32767, 32767, 65534, 65534, 65534, 160, 240);
    add_checked_point(-32768, -32768, -32768, -1, -1, -1, 160, 240);
    // Writes past the last register must leave the matrix and colors alone.
    add_write(CFG_SPARE_LO, 64'h0);
    add_write(CFG_SPARE_HI, 64'h0);
    add_checked_point(0, 0, 0, 32767, 32767, 32767, 160, 240);
    // Extreme matrix entries.
    add_write(ptcv_pkg::CFG_MAT_ROW0, 64'h8000_8000_8000_8000);
    add_write(ptcv_pkg::CFG_MAT_ROW1, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(ptcv_pkg::CFG_MAT_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(ptcv_pkg::CFG_MAT_ROW3, 64'h0001_0000_8000_7FFF);
    add_point(32767, 32767, 32767);
    add_point(-32768, -32768, -32768);
    add_point(0, 0, 0);
    add_point(-1, 1, -1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (directed_steps[n]) begin
      if (directed_steps[n].kind == STEP_WRITE) begin
        write_reg(directed_steps[n].idx, directed_steps[n].data);
      end else begin
        send_point(directed_steps[n].pt, directed_steps[n].typed, directed_steps[n].want);
      end
    end

    // Random phases, each with its own register setup and sender idling.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      randomize_setup();
      sender_idle_pct = PHASE_IDLE[phase];
      for (int n = 0; n < RANDOM_POINTS; n++) begin
        // Let the pipeline run dry once per phase before carrying on.
        if (n == RANDOM_POINTS / 2) begin
          wait_drained();
        end
        pt.pos_x = rand_coord();
        pt.pos_y = rand_coord();
        pt.pos_z = rand_coord();
        send_point(pt, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_vertices.size() != 0) begin
      report_mismatch($sformatf("%0d expected vertices never arrived", pending_vertices.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ptcv_pkg.sv
hw/rtl/ptcv_xform.sv
hw/rtl/point_to_cube_vertex_expander.sv
dv/tb_top.sv
